/* hdl/wsg_pkg.sv */
`timescale 1ns / 1ps

package wsg_pkg;

  localparam int unsigned WSG_NUM_WAYPOINTS = 5;
  localparam int unsigned WSG_PATH_STEP_DIV = 10;
  localparam int unsigned WSG_WP_IDX_W = 3;

  localparam logic signed [31:0] Q_ONE = 32'sd65536;
  localparam logic signed [31:0] Q_FOUR = 32'sd262144;

  localparam logic [30:0] GUARD_LIMIT_RST = 31'd196608;
  localparam logic [19:0] ARRIVE_RADIUS_RST = 20'd3277;

  typedef enum logic [2:0] {
    ACT_POSITION = 3'd0,
    ACT_TICK     = 3'd1,
    ACT_RESET    = 3'd2,
    ACT_LOITER   = 3'd3,
    ACT_PATH     = 3'd4,
    ACT_SETPOINT = 3'd5,
    ACT_MODE     = 3'd6
  } action_e;

  typedef enum logic [1:0] {
    MODE_MISSION  = 2'd0,
    MODE_MANUAL   = 2'd1,
    MODE_OFFBOARD = 2'd2,
    MODE_OTHER    = 2'd3
  } flight_mode_e;

  typedef enum logic [2:0] {
    REG_GUARD_LIMIT   = 3'd0,
    REG_ARRIVE_RADIUS = 3'd1,
    REG_HOME_X        = 3'd2,
    REG_HOME_Y        = 3'd3,
    REG_HOME_Z        = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } coord_t;

  typedef struct packed {
    logic [2:0]         action;
    logic               enable_flag;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [1:0]         flight_mode;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] sp_x;
    logic signed [31:0] sp_y;
    logic signed [31:0] sp_z;
    logic [31:0]        sequence_res;
    logic               guard_tripped;
  } out_item_t;

  typedef struct packed {
    logic [30:0] guard_limit;
    logic [19:0] arrive_radius;
    coord_t      home;
  } cfg_t;

  function automatic coord_t wp_point(input logic [WSG_WP_IDX_W-1:0] idx);
    coord_t c;
    case (idx)
      3'd1: c = '{x: 32'sd0, y: Q_ONE, z: Q_FOUR};
      3'd2: c = '{x: Q_ONE, y: Q_ONE, z: Q_FOUR};
      3'd3: c = '{x: Q_ONE, y: 32'sd0, z: Q_FOUR};
      default: c = '{x: 32'sd0, y: 32'sd0, z: Q_FOUR};
    endcase
    return c;
  endfunction

endpackage

/* hdl/wsg_cfg_regs.sv */
`timescale 1ns / 1ps

module wsg_cfg_regs
  import wsg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_GUARD_LIMIT:   cfg_d.guard_limit = cfg_data_i[30:0];
        REG_ARRIVE_RADIUS: cfg_d.arrive_radius = cfg_data_i[19:0];
        REG_HOME_X:        cfg_d.home.x = cfg_data_i;
        REG_HOME_Y:        cfg_d.home.y = cfg_data_i;
        REG_HOME_Z:        cfg_d.home.z = cfg_data_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.guard_limit   <= GUARD_LIMIT_RST;
      cfg_q.arrive_radius <= ARRIVE_RADIUS_RST;
      cfg_q.home.x        <= 32'sd0;
      cfg_q.home.y        <= 32'sd0;
      cfg_q.home.z        <= Q_FOUR;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hdl/wsg_core.sv */
`timescale 1ns / 1ps

module wsg_core
  import wsg_pkg::*;
#(
  parameter int unsigned NUM_WAYPOINTS     = WSG_NUM_WAYPOINTS,
  parameter int unsigned PATH_STEP_DIVISOR = WSG_PATH_STEP_DIV
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      item_valid_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output logic      res_valid_o,
  output out_item_t res_o
);

  // Division by the step divisor is a multiply by a scaled reciprocal, exact for 31-bit magnitudes.
  localparam int unsigned StepShift = 31 + $clog2(PATH_STEP_DIVISOR);
  localparam logic [31:0] StepMult = 32'(((64'd1 << StepShift) / PATH_STEP_DIVISOR) + 64'd1);
  localparam logic [WSG_WP_IDX_W-1:0] LastIdx = WSG_WP_IDX_W'(NUM_WAYPOINTS - 1);

  function automatic logic [32:0] mag33(input logic signed [31:0] a,
                                        input logic signed [31:0] b);
    logic [32:0] d;
    d = {a[31], a} - {b[31], b};
    return d[32] ? (~d + 33'd1) : d;
  endfunction

  function automatic logic guard_hit(input coord_t r, input coord_t p,
                                     input logic [30:0] lim);
    logic [32:0] l;
    l = {2'b00, lim};
    return (mag33(r.x, p.x) > l) || (mag33(r.y, p.y) > l) || (mag33(r.z, p.z) > l);
  endfunction

  function automatic logic signed [31:0] step_axis(input logic signed [31:0] t,
                                                   input logic signed [31:0] p);
    logic [32:0] d;
    logic [32:0] m;
    logic [62:0] prod;
    logic [31:0] q;
    d = {t[31], t} - {p[31], p};
    m = d[32] ? (~d + 33'd1) : d;
    prod = 63'(m[30:0]) * 63'(StepMult);
    q = 32'(prod >> StepShift);
    return d[32] ? (p - q) : (p + q);
  endfunction

  function automatic logic arrive_hit(input coord_t p, input coord_t t,
                                      input logic [19:0] r);
    logic [32:0] mx, my, mz, rr;
    logic [41:0] sum, rsq;
    mx = mag33(p.x, t.x);
    my = mag33(p.y, t.y);
    mz = mag33(p.z, t.z);
    rr = 33'(r);
    sum = 42'(mx[19:0]) * 42'(mx[19:0]) + 42'(my[19:0]) * 42'(my[19:0])
        + 42'(mz[19:0]) * 42'(mz[19:0]);
    rsq = 42'(r) * 42'(r);
    return (mx < rr) && (my < rr) && (mz < rr) && (sum < rsq);
  endfunction

  coord_t pos_q, pos_d, tgt_q, tgt_d, last_q, last_d;
  logic loiter_q, loiter_d, path_q, path_d, offb_q, offb_d;
  logic [WSG_WP_IDX_W-1:0] idx_q, idx_d, idx_adv;
  logic [31:0] tick_q, tick_d;

  coord_t in_pos, guard_ref, sp;
  logic trip;

  assign in_pos = '{x: item_i.pos_x, y: item_i.pos_y, z: item_i.pos_z};
  assign guard_ref = (loiter_q || path_q) ? tgt_q : last_q;
  assign trip = guard_hit(guard_ref, pos_q, cfg_i.guard_limit);
  assign idx_adv = (idx_q == LastIdx) ? '0 : idx_q + 1'b1;

  always_comb begin
    if (trip) begin
      sp = last_q;
    end else if (loiter_q) begin
      sp = tgt_q;
    end else if (path_q) begin
      sp.x = step_axis(tgt_q.x, pos_q.x);
      sp.y = step_axis(tgt_q.y, pos_q.y);
      sp.z = step_axis(tgt_q.z, pos_q.z);
    end else begin
      sp = pos_q;
    end
  end

  always_comb begin
    pos_d = pos_q;
    tgt_d = tgt_q;
    last_d = last_q;
    loiter_d = loiter_q;
    path_d = path_q;
    offb_d = offb_q;
    idx_d = idx_q;
    tick_d = tick_q;
    if (item_valid_i) begin
      case (action_e'(item_i.action))
        ACT_POSITION: begin
          pos_d = in_pos;
          if (path_q) begin
            idx_d = arrive_hit(in_pos, tgt_q, cfg_i.arrive_radius) ? idx_adv : idx_q;
            tgt_d = wp_point(idx_d);
          end
        end
        ACT_TICK: begin
          last_d = sp;
          tick_d = tick_q + 32'd1;
        end
        ACT_RESET: begin
          if (item_i.enable_flag) begin
            loiter_d = 1'b1;
            path_d = 1'b0;
          end
        end
        ACT_LOITER: begin
          loiter_d = item_i.enable_flag;
          tgt_d = item_i.enable_flag ? pos_q : cfg_i.home;
        end
        ACT_PATH: begin
          if (item_i.enable_flag) begin
            idx_d = '0;
            path_d = 1'b1;
          end else begin
            loiter_d = 1'b1;
            tgt_d = pos_q;
            path_d = 1'b0;
          end
        end
        ACT_SETPOINT: begin
          if (loiter_q) begin
            tgt_d = in_pos;
          end
        end
        ACT_MODE: begin
          if (item_i.flight_mode == MODE_MANUAL) begin
            offb_d = 1'b0;
          end else if (item_i.flight_mode == MODE_OFFBOARD && !offb_q) begin
            loiter_d = 1'b1;
            tgt_d = pos_q;
            offb_d = 1'b1;
          end
        end
        default: begin
          tick_d = tick_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      tgt_q <= '0;
      last_q <= '0;
      loiter_q <= 1'b0;
      path_q <= 1'b0;
      offb_q <= 1'b0;
      idx_q <= '0;
      tick_q <= '0;
    end else begin
      pos_q <= pos_d;
      tgt_q <= tgt_d;
      last_q <= last_d;
      loiter_q <= loiter_d;
      path_q <= path_d;
      offb_q <= offb_d;
      idx_q <= idx_d;
      tick_q <= tick_d;
    end
  end

  assign res_valid_o = item_valid_i && (item_i.action == ACT_TICK);
  assign res_o = '{sp_x: sp.x, sp_y: sp.y, sp_z: sp.z,
                   sequence_res: tick_q, guard_tripped: trip};

endmodule

/* hdl/waypoint_setpoint_guard_unit.sv */
`timescale 1ns / 1ps

// Setpoint generator with a per-axis guard. Every input transaction is one event; only a tick
// produces an output transaction, carrying the setpoint, the tick count before that tick and
// the guard flag. An accepted event is held in the input register and applied to the state as it
// leaves that register; a tick's result is then stored in the result register and offered from
// there. One event is taken every cycle; the input stalls only while a tick waits
// behind a result that the consumer has not yet taken. Configuration writes are always ready
// and are meant to happen while no event is in flight.
module waypoint_setpoint_guard_unit
  import wsg_pkg::*;
#(
  parameter int unsigned NUM_WAYPOINTS     = WSG_NUM_WAYPOINTS,
  parameter int unsigned PATH_STEP_DIVISOR = WSG_PATH_STEP_DIV
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_valid_q;
  logic      advance;
  logic      res_valid;
  out_item_t res;
  out_item_t out_q;
  logic      out_valid_q;

  assign cfg_ready_o = 1'b1;

  wsg_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign advance = in_valid_q && ((in_q.action != ACT_TICK) || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  wsg_core #(
    .NUM_WAYPOINTS     (NUM_WAYPOINTS),
    .PATH_STEP_DIVISOR (PATH_STEP_DIVISOR)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (advance),
    .item_i       (in_q),
    .cfg_i        (cfg),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

endmodule

/* hdl/wsg_checker.sv */
`timescale 1ns / 1ps

module wsg_checker
  import wsg_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input out_item_t   out_data_o
);

  logic [31:0] seq_exp_q;
  coord_t      prev_sp_q;
  logic        out_fire;

  assign out_fire = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_exp_q <= '0;
      prev_sp_q <= '0;
    end else if (out_fire) begin
      seq_exp_q <= out_data_o.sequence_res + 32'd1;
      prev_sp_q <= '{x: out_data_o.sp_x, y: out_data_o.sp_y, z: out_data_o.sp_z};
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("Output transaction changed while stalled.");

  a_seq_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.sequence_res == seq_exp_q)
    else $error("Output sequence number skipped or repeated.");

  a_guard_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.guard_tripped |->
      out_data_o.sp_x == prev_sp_q.x && out_data_o.sp_y == prev_sp_q.y &&
      out_data_o.sp_z == prev_sp_q.z)
    else $error("Guarded setpoint differs from the previous output.");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("Input stalled without a blocked output.");

endmodule

bind waypoint_setpoint_guard_unit wsg_checker u_wsg_checker (.*);
